// ----- rtl/wfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// wfpc_pkg
// Shared types, widths and constants of the waypoint-following controller.
// ----------------------------------------------------------------------------
package wfpc_pkg;

    // Signed offset between a waypoint and the pose, Q8.8.
    localparam int D_W   = 17;
    // Squared distance, Q.16.
    localparam int SQ_W  = 33;
    // Serial multiplier operand B and product widths.
    localparam int MB_W  = 17;
    localparam int P_W   = SQ_W + MB_W;
    // CORDIC datapath widths.
    localparam int XY_W  = 28;
    localparam int Z_W   = 34;
    localparam int ANG_W = 16;
    // Entries in the arctangent table and bits of its index.
    localparam int ATAN_N  = 24;
    localparam int ATAN_IW = 5;

    localparam logic signed [D_W-1:0] PI_Q12     = 17'sd12868;
    localparam logic signed [D_W-1:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [2:0] {
        REG_LIN_GAIN    = 3'd0,
        REG_ANG_GAIN    = 3'd1,
        REG_ACCEPT_SQ   = 3'd2,
        REG_MAX_HEAD    = 3'd3,
        REG_MAX_LIN     = 3'd4,
        REG_MAX_TURN    = 3'd5,
        REG_ARRIVAL     = 3'd6,
        REG_WP_COUNT    = 3'd7
    } t_reg_idx;

    // atan(2^-i) in Q.30, truncated.
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IW-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/waypoint_follow_p_controller.sv -----
// ----------------------------------------------------------------------------
// waypoint_follow_p_controller
// Proportional controller that steers a robot along a cyclic waypoint table.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  ------------------------------------
//  input    in         i_valid / o_stall  operation, slot, coord_x/y, heading
//  output   out        o_valid / i_stall  linear_cmd, angular_cmd, target_slot
//  config   in         APB (psel ...)     eight control registers
//
// A waypoint load completes in the cycle it is accepted. A pose transaction
// runs through one RAM read and two 17-step serial squarings per distance,
// once per waypoint plus once more for the chosen one on the first pose and
// once per skipped waypoint after that, then a CORDIC run and up to two
// more multiplications on the shared bit-serial multiplier.
// Reset is synchronous and active low; it restores the register defaults and
// clears the pursuit state but leaves the waypoint RAM unwritten.
// The output sits in a register, so a stalled result does not stop the next
// transaction from being accepted; only a second result waits for it.
// ----------------------------------------------------------------------------
module waypoint_follow_p_controller #(
    parameter int MAX_WAYPOINTS = 8,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [2:0]         i_slot,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic signed [14:0] i_heading,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [13:0] o_linear_cmd,
    output logic signed [14:0] o_angular_cmd,
    output logic [2:0]         o_target_slot,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DIFF, S_SQX, S_SQY, S_EVAL, S_CORD, S_ANG, S_LIN, S_FIN
    } t_state;

    // Configuration registers.
    logic [15:0]        r_lin_gain;
    logic [15:0]        r_ang_gain;
    logic [31:0]        r_accept;
    logic [13:0]        r_max_head;
    logic [12:0]        r_max_lin;
    logic [13:0]        r_max_turn;
    logic signed [13:0] r_arrival;
    logic [3:0]         r_wp_count;

    // Controller state.
    t_state                        r_state;
    logic                          r_have_pose;
    logic                          r_near;
    logic [AW-1:0]                 r_cur;
    logic [AW-1:0]                 r_idx;
    logic [CW-1:0]                 r_n;
    logic [CW-1:0]                 r_try;
    logic signed [15:0]            r_px;
    logic signed [15:0]            r_py;
    logic signed [14:0]            r_hd;
    logic signed [wfpc_pkg::D_W-1:0] r_dx;
    logic signed [wfpc_pkg::D_W-1:0] r_dy;
    logic [wfpc_pkg::SQ_W-1:0]     r_sq;
    logic [wfpc_pkg::SQ_W-1:0]     r_best;
    logic signed [14:0]            r_err;
    logic signed [14:0]            r_ang;
    logic signed [39:0]            r_lin_raw;
    logic signed [13:0]            r_held;
    logic                          r_mul_start;
    logic [wfpc_pkg::SQ_W-1:0]     r_mul_a;
    logic [wfpc_pkg::MB_W-1:0]     r_mul_b;
    logic                          r_cor_start;
    logic                          r_o_valid;
    logic signed [13:0]            r_o_lin;
    logic signed [14:0]            r_o_ang;
    logic [2:0]                    r_o_slot;

    // Datapath wires.
    logic                           cfg_wr;
    logic                           in_acc;
    logic                           out_free;
    logic                           ram_we;
    logic [31:0]                    ram_rdata;
    logic [CW-1:0]                  n_c;
    logic [AW-1:0]                  cur_cl;
    logic signed [wfpc_pkg::D_W-1:0] dx_c;
    logic signed [wfpc_pkg::D_W-1:0] dy_c;
    logic [wfpc_pkg::D_W-1:0]       adx;
    logic [wfpc_pkg::D_W-1:0]       ady;
    logic                           mul_done;
    logic [wfpc_pkg::P_W-1:0]       mul_prod;
    logic                           cor_done;
    logic signed [wfpc_pkg::ANG_W-1:0] cor_angle;
    logic signed [wfpc_pkg::D_W-1:0] e_raw;
    logic signed [wfpc_pkg::D_W-1:0] e_wrap;
    logic [14:0]                    e_abs15;
    logic [13:0]                    abs_err;
    logic signed [31:0]             ang_s;
    logic signed [31:0]             ang_r;
    logic signed [31:0]             turn_lim;
    logic signed [14:0]             ang_clip;
    logic [wfpc_pkg::P_W-1:0]       lin_rnd;
    logic signed [39:0]             lin_c;
    logic signed [39:0]             lin_lim;
    logic signed [13:0]             lin_clip;
    logic                           best_take;
    logic [AW-1:0]                  near_cur;
    logic [AW-1:0]                  next_slot;
    logic                           slot_ok;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= 16'd256;
            r_ang_gain <= 16'd768;
            r_accept   <= 32'd6554;
            r_max_head <= 14'd2145;
            r_max_lin  <= 13'd2048;
            r_max_turn <= 14'd4669;
            r_arrival  <= '0;
            r_wp_count <= 4'd7;
        end else if (cfg_wr) begin
            case (wfpc_pkg::t_reg_idx'(paddr[4:2]))
                wfpc_pkg::REG_LIN_GAIN:  r_lin_gain <= pwdata[15:0];
                wfpc_pkg::REG_ANG_GAIN:  r_ang_gain <= pwdata[15:0];
                wfpc_pkg::REG_ACCEPT_SQ: r_accept   <= pwdata;
                wfpc_pkg::REG_MAX_HEAD:  r_max_head <= pwdata[13:0];
                wfpc_pkg::REG_MAX_LIN:   r_max_lin  <= pwdata[12:0];
                wfpc_pkg::REG_MAX_TURN:  r_max_turn <= pwdata[13:0];
                wfpc_pkg::REG_ARRIVAL:   r_arrival  <= pwdata[13:0];
                wfpc_pkg::REG_WP_COUNT:  r_wp_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wfpc_pkg::t_reg_idx'(paddr[4:2]))
            wfpc_pkg::REG_LIN_GAIN:  prdata = {16'd0, r_lin_gain};
            wfpc_pkg::REG_ANG_GAIN:  prdata = {16'd0, r_ang_gain};
            wfpc_pkg::REG_ACCEPT_SQ: prdata = r_accept;
            wfpc_pkg::REG_MAX_HEAD:  prdata = {18'd0, r_max_head};
            wfpc_pkg::REG_MAX_LIN:   prdata = {19'd0, r_max_lin};
            wfpc_pkg::REG_MAX_TURN:  prdata = {18'd0, r_max_turn};
            wfpc_pkg::REG_ARRIVAL:   prdata = {18'd0, r_arrival};
            wfpc_pkg::REG_WP_COUNT:  prdata = {28'd0, r_wp_count};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Waypoint table: {x, y} per entry. Slots past the table are dropped.
    // ------------------------------------------------------------------
    assign slot_ok = ({29'd0, i_slot} < 32'(MAX_WAYPOINTS));
    assign ram_we  = in_acc && !i_operation && slot_ok;

    wfpc_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WAYPOINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // One multiplier serves the squares and both gain products.
    wfpc_smul #(
        .WA (wfpc_pkg::SQ_W),
        .WB (wfpc_pkg::MB_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    wfpc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (cor_done),
        .o_angle (cor_angle)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb begin
        // Effective waypoint count: zero acts as one, large values saturate.
        if (r_wp_count == '0) begin
            n_c = CW'(1);
        end else if (32'(r_wp_count) > 32'(MAX_WAYPOINTS)) begin
            n_c = CW'(MAX_WAYPOINTS);
        end else begin
            n_c = CW'(r_wp_count);
        end
        cur_cl = (32'(r_cur) >= 32'(n_c)) ? '0 : r_cur;

        dx_c = {ram_rdata[31], ram_rdata[31:16]} - {r_px[15], r_px};
        dy_c = {ram_rdata[15], ram_rdata[15:0]} - {r_py[15], r_py};
        adx  = dx_c[wfpc_pkg::D_W-1] ? -dx_c : dx_c;
        ady  = dy_c[wfpc_pkg::D_W-1] ? -dy_c : dy_c;

        // Heading error, wrapped once into (-pi, pi].
        e_raw = {cor_angle[wfpc_pkg::ANG_W-1], cor_angle} - {{2{r_hd[14]}}, r_hd};
        if (e_raw > wfpc_pkg::PI_Q12) begin
            e_wrap = e_raw - wfpc_pkg::TWO_PI_Q12;
        end else if (e_raw <= -wfpc_pkg::PI_Q12) begin
            e_wrap = e_raw + wfpc_pkg::TWO_PI_Q12;
        end else begin
            e_wrap = e_raw;
        end
        e_abs15 = r_err[14] ? -r_err : r_err;
        abs_err = e_abs15[13:0];

        // Angular command: sign restored, rounded half up, clipped.
        ang_s    = r_err[14] ? -{1'b0, mul_prod[30:0]} : {1'b0, mul_prod[30:0]};
        ang_r    = (ang_s + 32'sd128) >>> 8;
        turn_lim = {18'd0, r_max_turn};
        if (ang_r > turn_lim) begin
            ang_clip = turn_lim[14:0];
        end else if (ang_r < -turn_lim) begin
            ang_clip = -turn_lim[14:0];
        end else begin
            ang_clip = ang_r[14:0];
        end

        // Linear command before clipping.
        lin_rnd = mul_prod + wfpc_pkg::P_W'(2048);
        lin_c   = {2'b00, lin_rnd[49:12]} + {{26{r_arrival[13]}}, r_arrival};
        lin_lim = {27'd0, r_max_lin};
        if (r_lin_raw > lin_lim) begin
            lin_clip = lin_lim[13:0];
        end else if (r_lin_raw < -lin_lim) begin
            lin_clip = -lin_lim[13:0];
        end else begin
            lin_clip = r_lin_raw[13:0];
        end

        // Nearest search keeps the lowest index on ties.
        best_take = (r_idx == '0) || (r_sq < r_best);
        near_cur  = best_take ? r_idx : r_cur;
        next_slot = (32'(r_cur) + 32'd1 >= 32'(r_n)) ? '0 : r_cur + AW'(1);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_pose <= 1'b0;
            r_near      <= 1'b0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_n         <= CW'(1);
            r_try       <= '0;
            r_held      <= '0;
            r_mul_start <= 1'b0;
            r_cor_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_cor_start <= 1'b0;
            if (out_free && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_operation) begin
                        r_px  <= i_coord_x;
                        r_py  <= i_coord_y;
                        r_hd  <= i_heading;
                        r_n   <= n_c;
                        r_cur <= cur_cl;
                        r_try <= '0;
                        if (!r_have_pose) begin
                            r_near <= 1'b1;
                            r_idx  <= '0;
                        end else begin
                            r_near <= 1'b0;
                            r_idx  <= cur_cl;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx        <= dx_c;
                    r_dy        <= dy_c;
                    r_mul_a     <= wfpc_pkg::SQ_W'(adx);
                    r_mul_b     <= adx;
                    r_mul_start <= 1'b1;
                    r_state     <= S_SQX;
                end
                S_SQX: begin
                    if (mul_done) begin
                        r_sq        <= mul_prod[wfpc_pkg::SQ_W-1:0];
                        r_mul_a     <= wfpc_pkg::SQ_W'(ady);
                        r_mul_b     <= ady;
                        r_mul_start <= 1'b1;
                        r_state     <= S_SQY;
                    end
                end
                S_SQY: begin
                    if (mul_done) begin
                        r_sq    <= r_sq + mul_prod[wfpc_pkg::SQ_W-1:0];
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_near) begin
                        if (best_take) begin
                            r_best <= r_sq;
                        end
                        r_cur <= near_cur;
                        if (32'(r_idx) + 32'd1 < 32'(r_n)) begin
                            r_idx <= r_idx + AW'(1);
                        end else begin
                            r_have_pose <= 1'b1;
                            r_near      <= 1'b0;
                            r_idx       <= near_cur;
                        end
                        r_state <= S_RD;
                    end else if (r_sq >= {1'b0, r_accept}) begin
                        r_cor_start <= 1'b1;
                        r_state     <= S_CORD;
                    end else begin
                        r_cur <= next_slot;
                        r_idx <= next_slot;
                        r_try <= r_try + CW'(1);
                        // Every waypoint lies inside: no result.
                        if (32'(r_try) + 32'd1 == 32'(r_n)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_CORD: begin
                    if (cor_done) begin
                        r_err       <= e_wrap[14:0];
                        r_mul_a     <= wfpc_pkg::SQ_W'(e_wrap[14] ? -e_wrap : e_wrap);
                        r_mul_b     <= {1'b0, r_ang_gain};
                        r_mul_start <= 1'b1;
                        r_state     <= S_ANG;
                    end
                end
                S_ANG: begin
                    if (mul_done) begin
                        r_ang <= ang_clip;
                        if (abs_err < r_max_head) begin
                            r_mul_a     <= r_sq;
                            r_mul_b     <= {1'b0, r_lin_gain};
                            r_mul_start <= 1'b1;
                            r_state     <= S_LIN;
                        end else begin
                            r_lin_raw <= {{26{r_held[13]}}, r_held};
                            r_state   <= S_FIN;
                        end
                    end
                end
                S_LIN: begin
                    if (mul_done) begin
                        r_lin_raw <= lin_c;
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_held    <= lin_clip;
                        r_o_lin   <= lin_clip;
                        r_o_ang   <= r_ang;
                        r_o_slot  <= 3'(r_cur);
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_linear_cmd  = r_o_lin;
    assign o_angular_cmd = r_o_ang;
    assign o_target_slot = r_o_slot;

endmodule

// ----- rtl/wfpc_ram.sv -----
// ----------------------------------------------------------------------------
// wfpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wfpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wfpc_smul.sv -----
// ----------------------------------------------------------------------------
// wfpc_smul
// Unsigned shift-add multiplier that retires one bit of B per cycle.
// ----------------------------------------------------------------------------
module wfpc_smul #(
    parameter int WA = 33,
    parameter int WB = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic             o_done,
    output logic [WA+WB-1:0] o_prod
);

    localparam int CNT_W = $clog2(WB + 1);

    logic [WA+WB-1:0] r_acc;
    logic [WA-1:0]    r_a;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [WA:0]      sum;

    // Add the multiplicand into the upper half when the retiring bit is set.
    always_comb begin
        sum = {1'b0, r_acc[WA+WB-1:WB]} + (r_acc[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc <= {{WA{1'b0}}, i_b};
                r_a   <= i_a;
                r_cnt <= CNT_W'(WB);
            end else if (r_cnt != '0) begin
                r_acc <= {sum, r_acc[WB-1:1]};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- rtl/wfpc_cordic.sv -----
// ----------------------------------------------------------------------------
// wfpc_cordic
// Iterative vectoring CORDIC: atan2 of an offset, one rotation per cycle.
// ----------------------------------------------------------------------------
module wfpc_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic signed [wfpc_pkg::D_W-1:0]           i_dx,
    input  logic signed [wfpc_pkg::D_W-1:0]           i_dy,
    output logic                                      o_done,
    output logic signed [wfpc_pkg::ANG_W-1:0]         o_angle
);

    localparam int N = (STEPS < wfpc_pkg::ATAN_N) ? STEPS : wfpc_pkg::ATAN_N;

    logic                                r_busy;
    logic                                r_done;
    logic [wfpc_pkg::ATAN_IW-1:0]        r_i;
    logic signed [wfpc_pkg::XY_W-1:0]    r_x;
    logic signed [wfpc_pkg::XY_W-1:0]    r_y;
    logic signed [wfpc_pkg::Z_W-1:0]     r_z;
    logic signed [wfpc_pkg::XY_W-1:0]    x0;
    logic signed [wfpc_pkg::XY_W-1:0]    y0;
    logic signed [wfpc_pkg::XY_W-1:0]    xs;
    logic signed [wfpc_pkg::XY_W-1:0]    ys;
    logic signed [wfpc_pkg::Z_W-1:0]     z_round;

    always_comb begin
        x0      = {{3{i_dx[wfpc_pkg::D_W-1]}}, i_dx, 8'd0};
        y0      = {{3{i_dy[wfpc_pkg::D_W-1]}}, i_dy, 8'd0};
        xs      = r_x >>> r_i;
        ys      = r_y >>> r_i;
        z_round = r_z + wfpc_pkg::Z_W'(1 << 17);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_dx == '0 && i_dy == '0) begin
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    if (i_dx[wfpc_pkg::D_W-1]) begin
                        // Left half plane: rotate a quarter turn first.
                        if (!i_dy[wfpc_pkg::D_W-1]) begin
                            r_x <= y0;
                            r_y <= -x0;
                            r_z <= wfpc_pkg::HALF_PI_Q30;
                        end else begin
                            r_x <= -y0;
                            r_y <= x0;
                            r_z <= -wfpc_pkg::HALF_PI_Q30;
                        end
                    end else begin
                        r_x <= x0;
                        r_y <= y0;
                        r_z <= '0;
                    end
                end
            end else if (r_busy) begin
                if (!r_y[wfpc_pkg::XY_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + wfpc_pkg::atan_q30(r_i);
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - wfpc_pkg::atan_q30(r_i);
                end
                r_i <= r_i + wfpc_pkg::ATAN_IW'(1);
                if (r_i == wfpc_pkg::ATAN_IW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = z_round[wfpc_pkg::Z_W-1-:wfpc_pkg::ANG_W];

endmodule

// ----- rtl/wfpc_checker.sv -----
// ----------------------------------------------------------------------------
// wfpc_checker
// Port-level checks for the waypoint-following controller.
// ----------------------------------------------------------------------------
module wfpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_operation,
    input logic [2:0]         i_slot,
    input logic signed [15:0] i_coord_x,
    input logic signed [15:0] i_coord_y,
    input logic signed [14:0] i_heading,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [13:0] o_linear_cmd,
    input logic signed [14:0] o_angular_cmd,
    input logic [2:0]         o_target_slot,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [4:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_linear_cmd)
            && $stable(o_angular_cmd) && $stable(o_target_slot))
        else $error("stalled result changed");

    // A waypoint load finishes in the cycle it is taken.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_operation |=> !o_stall)
        else $error("load kept the block busy");

    // A pose keeps the block busy while it is worked on.
    a_pose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation |=> o_stall)
        else $error("pose did not occupy the block");

    // Clipping is symmetric, so the most negative codes never appear.
    a_clip_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_linear_cmd != 14'sh2000 && o_angular_cmd != 15'sh4000)
        else $error("command outside clip range");

    // A new result only appears at the end of pose work.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without pose work");

endmodule

bind waypoint_follow_p_controller wfpc_checker u_wfpc_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the waypoint-following controller: loads
// waypoint tables, streams pose transactions under random idling on both
// channels, predicts every velocity command and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

    // Idle time after the last expected command before the block may be
    // reconfigured. A pose that skips every waypoint gives no command, and the
    // first pose scans the whole table, so this covers the slowest such pose.
    localparam int SETTLE_CYCLES = 900;
    localparam int N_SLOTS       = 8;
    localparam longint HALF_PI   = 64'sd1686629713;
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_POSE     = 1'b1;

    typedef struct packed {
        logic signed [13:0] lin;
        logic signed [14:0] ang;
        logic [2:0]         slot;
    } t_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic [2:0]         i_slot = '0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic signed [14:0] i_heading = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [13:0] o_linear_cmd;
    logic signed [14:0] o_angular_cmd;
    logic [2:0]         o_target_slot;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    waypoint_follow_p_controller dut (.*);

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the control registers, starting at their reset values.
    longint cfg_lin_gain  = 256;
    longint cfg_ang_gain  = 768;
    longint cfg_accept    = 6554;
    longint cfg_max_head  = 2145;
    longint cfg_max_lin   = 2048;
    longint cfg_max_turn  = 4669;
    longint cfg_arrival   = 0;
    longint cfg_wp_count  = 7;

    // Shadow of the pursuit state and of the waypoint table.
    longint way_x [N_SLOTS];
    longint way_y [N_SLOTS];
    int     pursued_slot = 0;
    bit     pose_seen = 1'b0;
    longint held_lin = 0;

    // Commands still owed by the block, oldest first.
    t_cmd   cmd_due [$];

    int  errors = 0;
    int  n_loads = 0;
    int  n_poses = 0;
    int  n_silent = 0;
    int  n_cmds = 0;
    bit  calm = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // atan(2^-i) in Q.30, truncated.
    function automatic longint atan_step(int i);
        case (i)
            0:  return 64'h3243F6A8;
            1:  return 64'h1DAC6705;
            2:  return 64'h0FADBAFC;
            3:  return 64'h07F56EA6;
            4:  return 64'h03FEAB76;
            5:  return 64'h01FFD55B;
            6:  return 64'h00FFFAAA;
            7:  return 64'h007FFF55;
            8:  return 64'h003FFFEA;
            9:  return 64'h001FFFFD;
            10: return 64'h000FFFFF;
            11: return 64'h0007FFFF;
            12: return 64'h0003FFFF;
            13: return 64'h0001FFFF;
            14: return 64'h0000FFFF;
            15: return 64'h00007FFF;
            default: return 0;
        endcase
    endfunction

    // Bearing of the offset (dx, dy) in Q.12 radians, the way the CORDIC
    // vectoring datapath computes it, with a quarter-turn pre-rotation for
    // the left half plane.
    function automatic longint bearing_q12(longint dy, longint dx);
        longint x, y, z, t, xs, ys;
        int i;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI;
            end
        end
        for (i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return (z + (64'sd1 << 17)) >>> 18;
    endfunction

    function automatic longint range_sq(int s, longint px, longint py);
        longint dx, dy;
        dx = way_x[s] - px;
        dy = way_y[s] - py;
        return dx * dx + dy * dy;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Advance the shadow state by one accepted transaction and queue the
    // command it should produce, if any.
    task automatic steer_predict(logic op, logic [2:0] slot, logic signed [15:0] cx,
                                 logic signed [15:0] cy, logic signed [14:0] hd);
        longint px, py, sq, best, d, herr, ang, lin, aerr;
        logic signed [13:0] arr14;
        int n, i;
        bit found;
        t_cmd c;
        px = cx;
        py = cy;
        found = 1'b0;
        sq = 0;
        if (op == OP_LOAD) begin
            way_x[slot] = px;
            way_y[slot] = py;
            n_loads++;
            return;
        end
        n_poses++;
        n = int'(cfg_wp_count);
        if (n < 1) n = 1;
        if (n > N_SLOTS) n = N_SLOTS;
        if (pursued_slot >= n) pursued_slot = 0;
        // The first pose picks the nearest waypoint; ties go to the lowest slot.
        if (!pose_seen) begin
            best = 0;
            for (i = 0; i < n; i++) begin
                d = range_sq(i, px, py);
                if (i == 0 || d < best) begin
                    best = d;
                    pursued_slot = i;
                end
            end
            pose_seen = 1'b1;
        end
        // Skip waypoints already reached, at most once around the cycle.
        for (i = 0; i < n; i++) begin
            sq = range_sq(pursued_slot, px, py);
            if (sq >= cfg_accept) begin
                found = 1'b1;
                break;
            end
            pursued_slot = (pursued_slot + 1 >= n) ? 0 : pursued_slot + 1;
        end
        if (!found) begin
            n_silent++;
            return;
        end
        herr = bearing_q12(way_y[pursued_slot] - py, way_x[pursued_slot] - px) - longint'(hd);
        while (herr > 12868) herr -= 25736;
        while (herr <= -12868) herr += 25736;
        ang = clamp_mag((cfg_ang_gain * herr + 128) >>> 8, cfg_max_turn);
        aerr = (herr < 0) ? -herr : herr;
        arr14 = cfg_arrival[13:0];
        if (aerr < cfg_max_head)
            lin = ((cfg_lin_gain * sq + 2048) >>> 12) + longint'(arr14);
        else
            lin = held_lin;
        lin = clamp_mag(lin, cfg_max_lin);
        held_lin = lin;
        c.lin = lin[13:0];
        c.ang = ang[14:0];
        c.slot = pursued_slot[2:0];
        cmd_due.push_back(c);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts and the command checker
    // ------------------------------------------------------------------------

    int stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 18);
        end else begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    // A command is taken at each edge with o_valid high and i_stall low; the
    // values seen here are the ones from before the edge.
    always @(posedge i_clk) begin
        t_cmd exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            n_cmds++;
            if (cmd_due.size() == 0) begin
                $display("%0t: unexpected command lin=%0d ang=%0d slot=%0d",
                         $time, o_linear_cmd, o_angular_cmd, o_target_slot);
                errors++;
            end else begin
                exp_c = cmd_due.pop_front();
                if (o_linear_cmd !== exp_c.lin) begin
                    $display("%0t: linear_cmd expected %0d actual %0d",
                             $time, exp_c.lin, o_linear_cmd);
                    errors++;
                end
                if (o_angular_cmd !== exp_c.ang) begin
                    $display("%0t: angular_cmd expected %0d actual %0d",
                             $time, exp_c.ang, o_angular_cmd);
                    errors++;
                end
                if (o_target_slot !== exp_c.slot) begin
                    $display("%0t: target_slot expected %0d actual %0d",
                             $time, exp_c.slot, o_target_slot);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Send one transaction and wait for it to be taken. Valid stays high for
    // a back-to-back follow-up; it is only dropped when a gap is chosen.
    task automatic push_item(logic op, logic [2:0] slot, logic signed [15:0] cx,
                             logic signed [15:0] cy, logic signed [14:0] hd);
        int gap;
        i_valid <= 1'b1;
        i_operation <= op;
        i_slot <= slot;
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_heading <= hd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        steer_predict(op, slot, cx, cy, hd);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic sender_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every owed command has come out and any silent pose has
    // had time to finish.
    task automatic drain();
        sender_quiet();
        while (cmd_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(wfpc_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wfpc_pkg::REG_LIN_GAIN:  cfg_lin_gain = val[15:0];
            wfpc_pkg::REG_ANG_GAIN:  cfg_ang_gain = val[15:0];
            wfpc_pkg::REG_ACCEPT_SQ: cfg_accept = val;
            wfpc_pkg::REG_MAX_HEAD:  cfg_max_head = val[13:0];
            wfpc_pkg::REG_MAX_LIN:   cfg_max_lin = val[12:0];
            wfpc_pkg::REG_MAX_TURN:  cfg_max_turn = val[13:0];
            wfpc_pkg::REG_ARRIVAL:   cfg_arrival = val[13:0];
            wfpc_pkg::REG_WP_COUNT:  cfg_wp_count = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setup(int lg, int ag, logic [31:0] acc, int mh, int ml,
                               int mt, int arr, int cnt);
        reg_write(wfpc_pkg::REG_LIN_GAIN, lg);
        reg_write(wfpc_pkg::REG_ANG_GAIN, ag);
        reg_write(wfpc_pkg::REG_ACCEPT_SQ, acc);
        reg_write(wfpc_pkg::REG_MAX_HEAD, mh);
        reg_write(wfpc_pkg::REG_MAX_LIN, ml);
        reg_write(wfpc_pkg::REG_MAX_TURN, mt);
        reg_write(wfpc_pkg::REG_ARRIVAL, arr & 32'h3FFF);
        reg_write(wfpc_pkg::REG_WP_COUNT, cnt);
    endtask

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [14:0] any_heading();
        return 15'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fill the whole table, with corner coordinates and a duplicated pair of
    // waypoints so that the nearest-waypoint search sees a tie.
    task automatic test_table_load();
        push_item(OP_LOAD, 3'd0, 16'sh7FFF, 16'sh7FFF, 15'sd0);
        push_item(OP_LOAD, 3'd1, 16'sh8000, 16'sh8000, 15'sd0);
        push_item(OP_LOAD, 3'd2, 16'sd0, 16'sd0, 15'sd0);
        push_item(OP_LOAD, 3'd3, 16'sh8000, 16'sh7FFF, 15'sd0);
        push_item(OP_LOAD, 3'd4, 16'sh7FFF, 16'sh8000, 15'sd0);
        push_item(OP_LOAD, 3'd5, 16'sd512, 16'sd512, 15'sd0);
        push_item(OP_LOAD, 3'd6, 16'sd512, 16'sd512, 15'sd0);
        push_item(OP_LOAD, 3'd7, 16'sd1000, -16'sd500, 15'sd0);
    endtask

    // The first pose lands on the duplicated pair: the lower slot wins the
    // tie, both are already reached and get skipped.
    task automatic test_first_pose();
        push_item(OP_POSE, 3'd7, 16'sd512, 16'sd512, 15'sd12868);
        push_item(OP_POSE, 3'd0, 16'sh8000, 16'sh8000, -15'sd12868);
        push_item(OP_POSE, 3'd3, 16'sh7FFF, 16'sh8000, 15'sd0);
        push_item(OP_POSE, 3'd5, -16'sd300, 16'sd200, 15'sd6000);
    endtask

    // Register extremes, a pose sitting exactly on its target (zero offset),
    // the waypoint count outside its range and a pose with every waypoint
    // inside the acceptance circle.
    task automatic test_limits();
        drain();
        apply_setup(65535, 65535, 0, 12868, 8191, 16383, 8191, 8);
        push_item(OP_POSE, 3'd0, 16'sd1000, -16'sd500, 15'sd100);
        push_item(OP_POSE, 3'd0, 16'sd0, 16'sd1, -15'sd12868);
        push_item(OP_POSE, 3'd0, 16'sh7FFF, 16'sh7FFF, 15'sd12868);
        drain();
        apply_setup(0, 0, 1, 0, 0, 0, -8191, 1);
        push_item(OP_POSE, 3'd0, 16'sd5, 16'sd5, 15'sd0);
        push_item(OP_POSE, 3'd0, 16'sh8000, 16'sh7FFF, 15'sd3000);
        drain();
        apply_setup(300, 2000, 6554, 4000, 3000, 8000, 100, 0);
        push_item(OP_POSE, 3'd0, 16'sd700, -16'sd900, 15'sd1000);
        drain();
        reg_write(wfpc_pkg::REG_WP_COUNT, 15);
        push_item(OP_POSE, 3'd0, -16'sd700, 16'sd900, -15'sd1000);
        drain();
        reg_write(wfpc_pkg::REG_ACCEPT_SQ, 32'hFFFF_FFFF);
        push_item(OP_POSE, 3'd0, 16'sd0, 16'sd0, 15'sd0);
        push_item(OP_POSE, 3'd0, 16'sd10, 16'sd10, 15'sd0);
    endtask

    // Random traffic in several register settings. Most poses are placed
    // near a waypoint of the active cycle so that the skip logic works;
    // the rest roam the table area or the whole coordinate range.
    task automatic test_random(int phases, int per_phase);
        int p, k, s, n, sel;
        longint bx, by;
        for (p = 0; p < phases; p++) begin
            drain();
            if (p == phases - 1) calm = 1'b1;
            apply_setup($urandom_range(0, 65535) >> $urandom_range(0, 8),
                        $urandom_range(0, 65535) >> $urandom_range(0, 8),
                        $urandom_range(0, 40000), $urandom_range(0, 12868),
                        $urandom_range(0, 8191), $urandom_range(0, 16383),
                        $urandom_range(0, 16382) - 8191, $urandom_range(0, 15));
            // Every phase starts with a fresh table; the nearest search is not
            // renewed, so pursuit carries on from the slot pursued before.
            for (s = 0; s < N_SLOTS; s++)
                push_item(OP_LOAD, s[2:0], sat16($signed($urandom_range(0, 8000)) - 4000),
                          sat16($signed($urandom_range(0, 8000)) - 4000), any_heading());
            n = int'(cfg_wp_count);
            if (n < 1) n = 1;
            if (n > N_SLOTS) n = N_SLOTS;
            for (k = 0; k < per_phase; k++) begin
                sel = $urandom_range(0, 99);
                if (k == per_phase / 2 && p == 1) drain();
                if (sel < 12) begin
                    push_item(OP_LOAD, 3'($urandom_range(0, 7)),
                              16'($urandom), 16'($urandom), 15'($urandom));
                end else if (sel < 70) begin
                    s = (pursued_slot + $urandom_range(0, 1)) % n;
                    bx = way_x[s] + $signed($urandom_range(0, 240)) - 120;
                    by = way_y[s] + $signed($urandom_range(0, 240)) - 120;
                    push_item(OP_POSE, 3'($urandom_range(0, 7)), sat16(bx), sat16(by),
                              any_heading());
                end else if (sel < 88) begin
                    push_item(OP_POSE, 3'($urandom_range(0, 7)),
                              sat16($signed($urandom_range(0, 9000)) - 4500),
                              sat16($signed($urandom_range(0, 9000)) - 4500),
                              any_heading());
                end else begin
                    push_item(OP_POSE, 3'($urandom_range(0, 7)),
                              16'($urandom), 16'($urandom), any_heading());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_first_pose();
        test_limits();
        // Random part: loads leave table entries on the full range too.
        test_random(5, 160);
        drain();
        $display("Covered %0d waypoint loads and %0d poses; %0d commands checked,",
                 n_loads, n_poses, n_cmds);
        $display("%0d poses found every waypoint reached and gave no command.", n_silent);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d commands still owed.", cmd_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
